/* rtl/core/mrds_pkg.sv */
`default_nettype none

package mrds_pkg;

  // Number formats
  localparam int FRAC_BITS    = 24;
  localparam int WORD_BITS    = 32;
  localparam int FX_BITS      = 64;
  localparam int NEWTON_STEPS = 8;

  typedef logic signed [FX_BITS-1:0]   fx_t;
  typedef logic        [FX_BITS-1:0]   ufx_t;
  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [8:0][FX_BITS-1:0]     tens_t;

  localparam fx_t  FX_MAX      = {1'b0, {(FX_BITS-1){1'b1}}};
  localparam fx_t  FX_MIN      = {1'b1, {(FX_BITS-1){1'b0}}};
  localparam fx_t  ONE_Q       = fx_t'(ufx_t'(1) << FRAC_BITS);
  localparam ufx_t HALF_LSB    = ufx_t'(1) << (FRAC_BITS - 1);
  localparam ufx_t DIV3_MAGIC  = 64'hAAAA_AAAA_AAAA_AAAB;
  localparam fx_t  WORD_MAX_FX = fx_t'(ufx_t'(1) << (WORD_BITS - 1)) - fx_t'(1);
  localparam fx_t  WORD_MIN_FX = -WORD_MAX_FX - fx_t'(1);

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_M10 = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_M01 = 2'd1;

  // Unit latencies
  localparam int MUL_LAT   = 4;
  localparam int DIV3_LAT  = 4;
  localparam int FXDIV_LAT = FX_BITS + 2;
  localparam int STEP_LAT  = 4 * MUL_LAT + 1 + DIV3_LAT;

  // Item timeline, cycles after the accepting edge
  localparam int T_TR   = 1;
  localparam int T_U    = 2;
  localparam int T_ADJ  = MUL_LAT + 1;
  localparam int T_DET  = T_ADJ + MUL_LAT + 1;
  localparam int T_SQ   = MUL_LAT;
  localparam int T_CC   = T_SQ + 4;
  localparam int T_TRSQ = T_TR + MUL_LAT;
  localparam int T_B    = T_CC + 1;
  localparam int T_THB  = T_B + DIV3_LAT;
  localparam int T_THTR = T_TR + DIV3_LAT;
  localparam int T_Y0   = T_DET + 2;
  localparam int T_Y    = T_Y0 + NEWTON_STEPS * STEP_LAT;
  localparam int T_K1   = T_Y + MUL_LAT + 1;
  localparam int T_K2   = T_Y + 2 * MUL_LAT + 1;
  localparam int T_PRE  = T_K2 - MUL_LAT - 1;
  localparam int T_TADD = T_K2 - 1;
  localparam int T_INV  = T_DET + FXDIV_LAT;
  localparam int T_OUT  = T_K2 + MUL_LAT + 1;

  function automatic ufx_t mag(fx_t v);
    return v[FX_BITS-1] ? ufx_t'(-v) : ufx_t'(v);
  endfunction

  function automatic fx_t signed_sat(ufx_t m, logic neg);
    if (!neg) begin
      return m[FX_BITS-1] ? FX_MAX : fx_t'(m);
    end
    return m[FX_BITS-1] ? FX_MIN : -fx_t'(m);
  endfunction

  function automatic fx_t sat_add(fx_t a, fx_t b);
    logic signed [FX_BITS:0] s;
    s = {a[FX_BITS-1], a} + {b[FX_BITS-1], b};
    if (s[FX_BITS] != s[FX_BITS-1]) begin
      return s[FX_BITS] ? FX_MIN : FX_MAX;
    end
    return s[FX_BITS-1:0];
  endfunction

  function automatic fx_t sat_sub(fx_t a, fx_t b);
    logic signed [FX_BITS:0] s;
    s = {a[FX_BITS-1], a} - {b[FX_BITS-1], b};
    if (s[FX_BITS] != s[FX_BITS-1]) begin
      return s[FX_BITS] ? FX_MIN : FX_MAX;
    end
    return s[FX_BITS-1:0];
  endfunction

  function automatic word_t clamp_word(fx_t v);
    if (v > WORD_MAX_FX) begin
      return WORD_MAX_FX[WORD_BITS-1:0];
    end
    if (v < WORD_MIN_FX) begin
      return WORD_MIN_FX[WORD_BITS-1:0];
    end
    return v[WORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mrds_umul.sv */
`default_nettype none

// Unsigned 64x64 product from four registered 32x32 partial products
module mrds_umul (
  input  wire logic                  clk_i,
  input  wire mrds_pkg::ufx_t        a_i,
  input  wire mrds_pkg::ufx_t        b_i,
  output logic [2*mrds_pkg::FX_BITS-1:0] p_o
);

  localparam int H = mrds_pkg::FX_BITS / 2;
  localparam int P = 2 * mrds_pkg::FX_BITS;

  logic [2*H-1:0] pp00_q, pp01_q, pp10_q, pp11_q;
  logic [P-1:0]   p_q;

  // Form partial products
  always_ff @(posedge clk_i) begin
    pp00_q <= a_i[H-1:0] * b_i[H-1:0];
    pp01_q <= a_i[H-1:0] * b_i[2*H-1:H];
    pp10_q <= a_i[2*H-1:H] * b_i[H-1:0];
    pp11_q <= a_i[2*H-1:H] * b_i[2*H-1:H];
  end

  // Sum partial products
  always_ff @(posedge clk_i) begin
    p_q <= P'(pp00_q) + (P'(pp01_q) << H) + (P'(pp10_q) << H) + (P'(pp11_q) << (2*H));
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

/* rtl/core/mrds_mul.sv */
`default_nettype none

// Fixed-point multiply: round to nearest, ties away from zero, saturate
module mrds_mul (
  input  wire logic         clk_i,
  input  wire mrds_pkg::fx_t a_i,
  input  wire mrds_pkg::fx_t b_i,
  output mrds_pkg::fx_t      p_o
);

  localparam int P = 2 * mrds_pkg::FX_BITS;

  mrds_pkg::ufx_t am_q, bm_q;
  logic [2:0]     neg_q;
  logic [P-1:0]   prod;
  logic [P-1:0]   rnd;
  mrds_pkg::fx_t  p_q;

  // Split sign and magnitude
  always_ff @(posedge clk_i) begin
    am_q     <= mrds_pkg::mag(a_i);
    bm_q     <= mrds_pkg::mag(b_i);
    neg_q[0] <= a_i[mrds_pkg::FX_BITS-1] ^ b_i[mrds_pkg::FX_BITS-1];
    neg_q[1] <= neg_q[0];
    neg_q[2] <= neg_q[1];
  end

  mrds_umul u_umul (
    .clk_i (clk_i),
    .a_i   (am_q),
    .b_i   (bm_q),
    .p_o   (prod)
  );

  assign rnd = (prod + P'(mrds_pkg::HALF_LSB)) >> mrds_pkg::FRAC_BITS;

  // Round, drop fraction bits and saturate
  always_ff @(posedge clk_i) begin
    if (|rnd[P-1:mrds_pkg::FX_BITS]) begin
      p_q <= neg_q[2] ? mrds_pkg::FX_MIN : mrds_pkg::FX_MAX;
    end else begin
      p_q <= mrds_pkg::signed_sat(rnd[mrds_pkg::FX_BITS-1:0], neg_q[2]);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

/* rtl/core/mrds_div3.sv */
`default_nettype none

// Divide by three, rounded to nearest, via multiply by reciprocal
module mrds_div3 (
  input  wire logic          clk_i,
  input  wire mrds_pkg::fx_t v_i,
  output mrds_pkg::fx_t      q_o
);

  localparam int P = 2 * mrds_pkg::FX_BITS;

  mrds_pkg::ufx_t x_q;
  logic [2:0]     neg_q;
  logic [P-1:0]   prod;
  mrds_pkg::fx_t  q_q;

  // Bias magnitude by one for rounding
  always_ff @(posedge clk_i) begin
    x_q      <= mrds_pkg::mag(v_i) + mrds_pkg::ufx_t'(1);
    neg_q[0] <= v_i[mrds_pkg::FX_BITS-1];
    neg_q[1] <= neg_q[0];
    neg_q[2] <= neg_q[1];
  end

  mrds_umul u_umul (
    .clk_i (clk_i),
    .a_i   (x_q),
    .b_i   (mrds_pkg::DIV3_MAGIC),
    .p_o   (prod)
  );

  // Take quotient and restore sign
  always_ff @(posedge clk_i) begin
    q_q <= mrds_pkg::signed_sat(mrds_pkg::ufx_t'(prod[P-1:mrds_pkg::FX_BITS+1]), neg_q[2]);
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

/* rtl/core/mrds_div.sv */
`default_nettype none

// Fixed-point divide n/d (d > 0), one quotient bit per stage, rounded
module mrds_div (
  input  wire logic          clk_i,
  input  wire mrds_pkg::fx_t n_i,
  input  wire mrds_pkg::fx_t d_i,
  output mrds_pkg::fx_t      q_o
);

  localparam int N = mrds_pkg::FX_BITS;

  mrds_pkg::ufx_t r_q   [0:N];
  mrds_pkg::ufx_t lq_q  [0:N];
  mrds_pkg::ufx_t d_q   [0:N];
  logic           neg_q [0:N];
  logic           ovf_q [0:N];
  mrds_pkg::ufx_t m;
  mrds_pkg::ufx_t hi;
  mrds_pkg::ufx_t rest;
  logic           rnd_up;
  mrds_pkg::fx_t  q_q;

  assign m  = mrds_pkg::mag(n_i);
  assign hi = m >> (N - mrds_pkg::FRAC_BITS);

  // Load dividend, flag quotient overflow
  always_ff @(posedge clk_i) begin
    r_q[0]   <= hi;
    lq_q[0]  <= m << mrds_pkg::FRAC_BITS;
    d_q[0]   <= mrds_pkg::ufx_t'(d_i);
    neg_q[0] <= n_i[N-1];
    ovf_q[0] <= hi >= mrds_pkg::ufx_t'(d_i);
  end

  // Restoring division stages
  for (genvar k = 1; k <= N; k++) begin : g_stage
    mrds_pkg::ufx_t rs;
    logic           ge;
    assign rs = {r_q[k-1][N-2:0], lq_q[k-1][N-1]};
    assign ge = r_q[k-1][N-1] || (rs >= d_q[k-1]);
    always_ff @(posedge clk_i) begin
      r_q[k]   <= ge ? rs - d_q[k-1] : rs;
      lq_q[k]  <= {lq_q[k-1][N-2:0], ge};
      d_q[k]   <= d_q[k-1];
      neg_q[k] <= neg_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
    end
  end

  assign rest   = d_q[N] - r_q[N];
  assign rnd_up = r_q[N] >= rest;

  // Round to nearest and saturate
  always_ff @(posedge clk_i) begin
    if (ovf_q[N] || (rnd_up && (&lq_q[N]))) begin
      q_q <= neg_q[N] ? mrds_pkg::FX_MIN : mrds_pkg::FX_MAX;
    end else begin
      q_q <= mrds_pkg::signed_sat(lq_q[N] + mrds_pkg::ufx_t'(rnd_up), neg_q[N]);
    end
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

/* rtl/core/mrds_cbrt_step.sv */
`default_nettype none

// One Newton step y <- (4y - d*y^4)/3
module mrds_cbrt_step (
  input  wire logic          clk_i,
  input  wire mrds_pkg::fx_t d_i,
  input  wire mrds_pkg::fx_t y_i,
  output mrds_pkg::fx_t      d_o,
  output mrds_pkg::fx_t      y_o
);

  localparam int YL = 4 * mrds_pkg::MUL_LAT - 1;
  localparam int DL = mrds_pkg::STEP_LAT;

  mrds_pkg::fx_t yd_q [1:YL];
  mrds_pkg::fx_t dd_q [1:DL];
  mrds_pkg::fx_t m1, m2, m3, t;
  mrds_pkg::fx_t y4_q, diff_q;

  // Carry y and d alongside the multiply chain
  always_ff @(posedge clk_i) begin
    yd_q[1] <= y_i;
    for (int k = 2; k <= YL; k++) begin
      yd_q[k] <= yd_q[k-1];
    end
    dd_q[1] <= d_i;
    for (int k = 2; k <= DL; k++) begin
      dd_q[k] <= dd_q[k-1];
    end
  end

  mrds_mul u_m1 (.clk_i(clk_i), .a_i(d_i), .b_i(y_i), .p_o(m1));
  mrds_mul u_m2 (.clk_i(clk_i), .a_i(m1), .b_i(yd_q[mrds_pkg::MUL_LAT]), .p_o(m2));
  mrds_mul u_m3 (.clk_i(clk_i), .a_i(m2), .b_i(yd_q[2*mrds_pkg::MUL_LAT]), .p_o(m3));
  mrds_mul u_m4 (.clk_i(clk_i), .a_i(m3), .b_i(yd_q[3*mrds_pkg::MUL_LAT]), .p_o(t));

  // Form 4y, then subtract d*y^4
  always_ff @(posedge clk_i) begin
    y4_q   <= mrds_pkg::sat_add(mrds_pkg::sat_add(yd_q[YL], yd_q[YL]),
                                mrds_pkg::sat_add(yd_q[YL], yd_q[YL]));
    diff_q <= mrds_pkg::sat_sub(y4_q, t);
  end

  mrds_div3 u_div3 (.clk_i(clk_i), .v_i(diff_q), .q_o(y_o));

  assign d_o = dd_q[DL];

endmodule

`default_nettype wire

/* rtl/core/mrds_cbrt.sv */
`default_nettype none

// d^(-1/3): power-of-two start from the leading one, then Newton steps
module mrds_cbrt (
  input  wire logic          clk_i,
  input  wire mrds_pkg::fx_t d_i,
  output mrds_pkg::fx_t      y_o
);

  localparam int S = mrds_pkg::NEWTON_STEPS;

  logic [7:0]       nz_q;
  logic [7:0][2:0]  pos_q;
  logic [7:0]       nz_d;
  logic [7:0][2:0]  pos_d;
  mrds_pkg::fx_t    da_q, y0_q, d0_q;
  mrds_pkg::fx_t    y0_d;
  mrds_pkg::fx_t    d_chain [0:S];
  mrds_pkg::fx_t    y_chain [0:S];

  // Leading one inside each byte
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      nz_d[b]  = |d_i[8*b +: 8];
      pos_d[b] = 3'd0;
      for (int i = 0; i < 8; i++) begin
        if (d_i[8*b+i]) begin
          pos_d[b] = 3'(i);
        end
      end
    end
  end

  // Pick the top byte and form the starting power of two
  always_comb begin
    int p;
    int x;
    int c;
    int sh;
    p = 0;
    for (int b = 0; b < 8; b++) begin
      if (nz_q[b]) begin
        p = 8 * b + int'(pos_q[b]);
      end
    end
    x  = p - mrds_pkg::FRAC_BITS + 128;
    c  = ((x * 171) >>> 9) - 42;
    sh = mrds_pkg::FRAC_BITS - c;
    if (sh < 0) begin
      sh = 0;
    end
    y0_d = mrds_pkg::fx_t'(mrds_pkg::ufx_t'(1) << sh[5:0]);
  end

  always_ff @(posedge clk_i) begin
    nz_q  <= nz_d;
    pos_q <= pos_d;
    da_q  <= d_i;
    y0_q  <= y0_d;
    d0_q  <= da_q;
  end

  assign d_chain[0] = d0_q;
  assign y_chain[0] = y0_q;

  for (genvar s = 0; s < S; s++) begin : g_step
    mrds_cbrt_step u_step (
      .clk_i (clk_i),
      .d_i   (d_chain[s]),
      .y_i   (y_chain[s]),
      .d_o   (d_chain[s+1]),
      .y_o   (y_chain[s+1])
    );
  end

  assign y_o = y_chain[S];

endmodule

`default_nettype wire

/* rtl/core/mrds_lane.sv */
`default_nettype none

// One stress component: inverse entry, the two terms and their sum
module mrds_lane (
  input  wire logic            clk_i,
  input  wire logic            diag_i,
  input  wire mrds_pkg::fx_t   adj_i,
  input  wire mrds_pkg::fx_t   det_i,
  input  wire mrds_pkg::fx_t   third_tr_i,
  input  wire mrds_pkg::fx_t   third_b_i,
  input  wire mrds_pkg::fx_t   u_i,
  input  wire mrds_pkg::fx_t   k1_i,
  input  wire mrds_pkg::fx_t   k2_i,
  input  wire logic            bad_i,
  output mrds_pkg::word_t      s_o
);

  localparam int IW = mrds_pkg::T_PRE - mrds_pkg::T_INV;

  mrds_pkg::fx_t   inv;
  mrds_pkg::fx_t   inv_q [1:IW];
  mrds_pkg::fx_t   pa, pb, t1_q, t2_q, q1, q2;
  mrds_pkg::word_t s_q;

  mrds_div u_div (.clk_i(clk_i), .n_i(adj_i), .d_i(det_i), .q_o(inv));

  // Hold the inverse entry until J3 is ready
  always_ff @(posedge clk_i) begin
    inv_q[1] <= inv;
    for (int k = 2; k <= IW; k++) begin
      inv_q[k] <= inv_q[k-1];
    end
  end

  mrds_mul u_pa (.clk_i(clk_i), .a_i(third_tr_i), .b_i(inv_q[IW]), .p_o(pa));
  mrds_mul u_pb (.clk_i(clk_i), .a_i(third_b_i), .b_i(inv_q[IW]), .p_o(pb));

  // Build both bracket terms
  always_ff @(posedge clk_i) begin
    t1_q <= mrds_pkg::sat_sub(diag_i ? mrds_pkg::ONE_Q : '0, pa);
    t2_q <= mrds_pkg::sat_add(u_i, pb);
  end

  mrds_mul u_q1 (.clk_i(clk_i), .a_i(k1_i), .b_i(t1_q), .p_o(q1));
  mrds_mul u_q2 (.clk_i(clk_i), .a_i(k2_i), .b_i(t2_q), .p_o(q2));

  // Sum, clamp to word, zero on a bad determinant
  always_ff @(posedge clk_i) begin
    s_q <= bad_i ? '0 : mrds_pkg::clamp_word(mrds_pkg::sat_add(q1, q2));
  end

  assign s_o = s_q;

endmodule

`default_nettype wire

/* rtl/core/mooney_rivlin_deviatoric_stress.sv */
`default_nettype none

// Channel      | Ports                                   | Handshake
// -------------+-----------------------------------------+---------------------------
// tensor in    | start_i, busy_o, c_11_i .. c_33_i       | start_i && !busy_o
// stress out   | done_o, s_11_o .. s_33_o, bad_determinant_o | done_o, one cycle
// config write | cfg_we_i, cfg_idx_i, cfg_data_i         | cfg_we_i
//
// Fully pipelined: one tensor per cycle, busy_o stays low.
// Latency is set by the eight Newton steps of det^-1/3, each four
// chained multiplies plus a divide-by-three.
// Nine lanes run in parallel, each with a 64-stage bit-per-stage divider.
// rst_ni clears the pipeline valid bits and both coefficients.
// The receiver cannot stall; every result shows on done_o for one cycle.
module mooney_rivlin_deviatoric_stress (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic signed [mrds_pkg::WORD_BITS-1:0] c_11_i,
  input  wire logic signed [mrds_pkg::WORD_BITS-1:0] c_12_i,
  input  wire logic signed [mrds_pkg::WORD_BITS-1:0] c_13_i,
  input  wire logic signed [mrds_pkg::WORD_BITS-1:0] c_21_i,
  input  wire logic signed [mrds_pkg::WORD_BITS-1:0] c_22_i,
  input  wire logic signed [mrds_pkg::WORD_BITS-1:0] c_23_i,
  input  wire logic signed [mrds_pkg::WORD_BITS-1:0] c_31_i,
  input  wire logic signed [mrds_pkg::WORD_BITS-1:0] c_32_i,
  input  wire logic signed [mrds_pkg::WORD_BITS-1:0] c_33_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [mrds_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [mrds_pkg::WORD_BITS-1:0]      cfg_data_i,
  output logic                                     done_o,
  output logic signed [mrds_pkg::WORD_BITS-1:0]    s_11_o,
  output logic signed [mrds_pkg::WORD_BITS-1:0]    s_12_o,
  output logic signed [mrds_pkg::WORD_BITS-1:0]    s_13_o,
  output logic signed [mrds_pkg::WORD_BITS-1:0]    s_21_o,
  output logic signed [mrds_pkg::WORD_BITS-1:0]    s_22_o,
  output logic signed [mrds_pkg::WORD_BITS-1:0]    s_23_o,
  output logic signed [mrds_pkg::WORD_BITS-1:0]    s_31_o,
  output logic signed [mrds_pkg::WORD_BITS-1:0]    s_32_o,
  output logic signed [mrds_pkg::WORD_BITS-1:0]    s_33_o,
  output logic                                     bad_determinant_o
);

  localparam int L_ADJ  = mrds_pkg::T_DET - mrds_pkg::T_ADJ;
  localparam int L_C    = mrds_pkg::T_ADJ;
  localparam int L_TRSQ = mrds_pkg::T_CC - mrds_pkg::T_TRSQ;
  localparam int L_THTR = mrds_pkg::T_PRE - mrds_pkg::T_THTR;
  localparam int L_THB  = mrds_pkg::T_PRE - mrds_pkg::T_THB;
  localparam int L_U    = mrds_pkg::T_TADD - mrds_pkg::T_U;
  localparam int L_BAD  = mrds_pkg::T_OUT - 1 - mrds_pkg::T_DET;
  localparam int L_K1   = mrds_pkg::T_K2 - mrds_pkg::T_K1;
  localparam int L_VLD  = mrds_pkg::T_OUT;

  mrds_pkg::fx_t   m10_q, m01_q;
  mrds_pkg::fx_t   c_in [9];
  mrds_pkg::tens_t c_now;
  mrds_pkg::tens_t cd_q  [0:L_C-1];
  mrds_pkg::fx_t   pa [9];
  mrds_pkg::fx_t   pb [9];
  mrds_pkg::fx_t   sq [9];
  mrds_pkg::tens_t adj_q [0:L_ADJ];
  mrds_pkg::fx_t   dp [3];
  mrds_pkg::fx_t   det_q;
  mrds_pkg::fx_t   tr_q;
  mrds_pkg::tens_t u_d;
  mrds_pkg::tens_t u_q [0:L_U];
  mrds_pkg::fx_t   sq34_q [2];
  mrds_pkg::fx_t   sq56_q [2][2];
  mrds_pkg::fx_t   sq78_q [2][3];
  mrds_pkg::fx_t   acc5_q, acc6_q, acc7_q, cc_q;
  mrds_pkg::fx_t   trsq;
  mrds_pkg::fx_t   trsq_q [1:L_TRSQ];
  mrds_pkg::fx_t   b_q;
  mrds_pkg::fx_t   thtr, thb;
  mrds_pkg::fx_t   thtr_q [1:L_THTR];
  mrds_pkg::fx_t   thb_q  [1:L_THB];
  logic            bad_q  [1:L_BAD];
  logic [L_VLD:1]  vld_q;
  mrds_pkg::fx_t   y, y2, my, my2;
  mrds_pkg::fx_t   k1_q [0:L_K1];
  mrds_pkg::fx_t   k2_q;
  mrds_pkg::word_t s [9];

  assign busy_o = 1'b0;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m10_q <= '0;
      m01_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mrds_pkg::CFG_M10: m10_q <= mrds_pkg::fx_t'(signed'(cfg_data_i));
        mrds_pkg::CFG_M01: m01_q <= mrds_pkg::fx_t'(signed'(cfg_data_i));
        default: ;
      endcase
    end
  end

  // Widen tensor entries
  assign c_in[0] = mrds_pkg::fx_t'(c_11_i);
  assign c_in[1] = mrds_pkg::fx_t'(c_12_i);
  assign c_in[2] = mrds_pkg::fx_t'(c_13_i);
  assign c_in[3] = mrds_pkg::fx_t'(c_21_i);
  assign c_in[4] = mrds_pkg::fx_t'(c_22_i);
  assign c_in[5] = mrds_pkg::fx_t'(c_23_i);
  assign c_in[6] = mrds_pkg::fx_t'(c_31_i);
  assign c_in[7] = mrds_pkg::fx_t'(c_32_i);
  assign c_in[8] = mrds_pkg::fx_t'(c_33_i);

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      c_now[i] = c_in[i];
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[L_VLD-1:1], start_i && !busy_o};
    end
  end

  // Carry the tensor to the determinant products
  always_ff @(posedge clk_i) begin
    cd_q[0] <= c_now;
    for (int k = 1; k < L_C; k++) begin
      cd_q[k] <= cd_q[k-1];
    end
  end

  // Cofactor products
  mrds_mul u_a0a (.clk_i(clk_i), .a_i(c_in[4]), .b_i(c_in[8]), .p_o(pa[0]));
  mrds_mul u_a0b (.clk_i(clk_i), .a_i(c_in[5]), .b_i(c_in[7]), .p_o(pb[0]));
  mrds_mul u_a1a (.clk_i(clk_i), .a_i(c_in[2]), .b_i(c_in[7]), .p_o(pa[1]));
  mrds_mul u_a1b (.clk_i(clk_i), .a_i(c_in[1]), .b_i(c_in[8]), .p_o(pb[1]));
  mrds_mul u_a2a (.clk_i(clk_i), .a_i(c_in[1]), .b_i(c_in[5]), .p_o(pa[2]));
  mrds_mul u_a2b (.clk_i(clk_i), .a_i(c_in[2]), .b_i(c_in[4]), .p_o(pb[2]));
  mrds_mul u_a3a (.clk_i(clk_i), .a_i(c_in[5]), .b_i(c_in[6]), .p_o(pa[3]));
  mrds_mul u_a3b (.clk_i(clk_i), .a_i(c_in[3]), .b_i(c_in[8]), .p_o(pb[3]));
  mrds_mul u_a4a (.clk_i(clk_i), .a_i(c_in[0]), .b_i(c_in[8]), .p_o(pa[4]));
  mrds_mul u_a4b (.clk_i(clk_i), .a_i(c_in[2]), .b_i(c_in[6]), .p_o(pb[4]));
  mrds_mul u_a5a (.clk_i(clk_i), .a_i(c_in[2]), .b_i(c_in[3]), .p_o(pa[5]));
  mrds_mul u_a5b (.clk_i(clk_i), .a_i(c_in[0]), .b_i(c_in[5]), .p_o(pb[5]));
  mrds_mul u_a6a (.clk_i(clk_i), .a_i(c_in[3]), .b_i(c_in[7]), .p_o(pa[6]));
  mrds_mul u_a6b (.clk_i(clk_i), .a_i(c_in[4]), .b_i(c_in[6]), .p_o(pb[6]));
  mrds_mul u_a7a (.clk_i(clk_i), .a_i(c_in[1]), .b_i(c_in[6]), .p_o(pa[7]));
  mrds_mul u_a7b (.clk_i(clk_i), .a_i(c_in[0]), .b_i(c_in[7]), .p_o(pb[7]));
  mrds_mul u_a8a (.clk_i(clk_i), .a_i(c_in[0]), .b_i(c_in[4]), .p_o(pa[8]));
  mrds_mul u_a8b (.clk_i(clk_i), .a_i(c_in[1]), .b_i(c_in[3]), .p_o(pb[8]));

  // Adjugate, then hold it for the dividers
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      adj_q[0][i] <= mrds_pkg::sat_sub(pa[i], pb[i]);
    end
    for (int k = 1; k <= L_ADJ; k++) begin
      adj_q[k] <= adj_q[k-1];
    end
  end

  // Determinant by first-row expansion
  mrds_mul u_d0 (.clk_i(clk_i), .a_i(cd_q[L_C-1][0]), .b_i(adj_q[0][0]), .p_o(dp[0]));
  mrds_mul u_d1 (.clk_i(clk_i), .a_i(cd_q[L_C-1][1]), .b_i(adj_q[0][3]), .p_o(dp[1]));
  mrds_mul u_d2 (.clk_i(clk_i), .a_i(cd_q[L_C-1][2]), .b_i(adj_q[0][6]), .p_o(dp[2]));

  always_ff @(posedge clk_i) begin
    det_q <= mrds_pkg::sat_add(mrds_pkg::sat_add(dp[0], dp[1]), dp[2]);
  end

  // Trace, and the diagonal-minus-entry term per lane
  always_ff @(posedge clk_i) begin
    tr_q <= mrds_pkg::sat_add(mrds_pkg::sat_add(c_in[0], c_in[4]), c_in[8]);
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      u_d[i] = mrds_pkg::sat_sub(((i == 0) || (i == 4) || (i == 8)) ? tr_q : '0,
                                 mrds_pkg::fx_t'(cd_q[0][i]));
    end
  end

  always_ff @(posedge clk_i) begin
    u_q[0] <= u_d;
    for (int k = 1; k <= L_U; k++) begin
      u_q[k] <= u_q[k-1];
    end
  end

  // Sum of squared entries, accumulated in order
  for (genvar i = 0; i < 9; i++) begin : g_sq
    mrds_mul u_sq (.clk_i(clk_i), .a_i(c_in[i]), .b_i(c_in[i]), .p_o(sq[i]));
  end

  always_ff @(posedge clk_i) begin
    sq34_q[0]    <= sq[3];
    sq34_q[1]    <= sq[4];
    sq56_q[0][0] <= sq[5];
    sq56_q[0][1] <= sq56_q[0][0];
    sq56_q[1][0] <= sq[6];
    sq56_q[1][1] <= sq56_q[1][0];
    sq78_q[0][0] <= sq[7];
    sq78_q[0][1] <= sq78_q[0][0];
    sq78_q[0][2] <= sq78_q[0][1];
    sq78_q[1][0] <= sq[8];
    sq78_q[1][1] <= sq78_q[1][0];
    sq78_q[1][2] <= sq78_q[1][1];
    acc5_q <= mrds_pkg::sat_add(mrds_pkg::sat_add(sq[0], sq[1]), sq[2]);
    acc6_q <= mrds_pkg::sat_add(mrds_pkg::sat_add(acc5_q, sq34_q[0]), sq34_q[1]);
    acc7_q <= mrds_pkg::sat_add(mrds_pkg::sat_add(acc6_q, sq56_q[0][1]), sq56_q[1][1]);
    cc_q   <= mrds_pkg::sat_add(mrds_pkg::sat_add(acc7_q, sq78_q[0][2]), sq78_q[1][2]);
  end

  // Trace squared and the second-invariant bracket
  mrds_mul u_trsq (.clk_i(clk_i), .a_i(tr_q), .b_i(tr_q), .p_o(trsq));

  always_ff @(posedge clk_i) begin
    trsq_q[1] <= trsq;
    for (int k = 2; k <= L_TRSQ; k++) begin
      trsq_q[k] <= trsq_q[k-1];
    end
    b_q <= mrds_pkg::sat_sub(cc_q, trsq_q[L_TRSQ]);
  end

  mrds_div3 u_thtr (.clk_i(clk_i), .v_i(tr_q), .q_o(thtr));
  mrds_div3 u_thb  (.clk_i(clk_i), .v_i(b_q),  .q_o(thb));

  // Hold thirds and the error flag for the lanes
  always_ff @(posedge clk_i) begin
    thtr_q[1] <= thtr;
    for (int k = 2; k <= L_THTR; k++) begin
      thtr_q[k] <= thtr_q[k-1];
    end
    thb_q[1] <= thb;
    for (int k = 2; k <= L_THB; k++) begin
      thb_q[k] <= thb_q[k-1];
    end
    bad_q[1] <= (det_q <= mrds_pkg::fx_t'(0));
    for (int k = 2; k <= L_BAD; k++) begin
      bad_q[k] <= bad_q[k-1];
    end
  end

  // J3 and its square, then both scale factors
  mrds_cbrt u_cbrt (.clk_i(clk_i), .d_i(det_q), .y_o(y));

  mrds_mul u_y2  (.clk_i(clk_i), .a_i(y),     .b_i(y),  .p_o(y2));
  mrds_mul u_my  (.clk_i(clk_i), .a_i(m10_q), .b_i(y),  .p_o(my));
  mrds_mul u_my2 (.clk_i(clk_i), .a_i(m01_q), .b_i(y2), .p_o(my2));

  always_ff @(posedge clk_i) begin
    k1_q[0] <= mrds_pkg::sat_add(my, my);
    for (int k = 1; k <= L_K1; k++) begin
      k1_q[k] <= k1_q[k-1];
    end
    k2_q <= mrds_pkg::sat_add(my2, my2);
  end

  // Component lanes
  for (genvar i = 0; i < 9; i++) begin : g_lane
    mrds_lane u_lane (
      .clk_i      (clk_i),
      .diag_i     ((i == 0) || (i == 4) || (i == 8)),
      .adj_i      (mrds_pkg::fx_t'(adj_q[L_ADJ][i])),
      .det_i      (det_q),
      .third_tr_i (thtr_q[L_THTR]),
      .third_b_i  (thb_q[L_THB]),
      .u_i        (mrds_pkg::fx_t'(u_q[L_U][i])),
      .k1_i       (k1_q[L_K1]),
      .k2_i       (k2_q),
      .bad_i      (bad_q[L_BAD]),
      .s_o        (s[i])
    );
  end

  // Drive result ports
  always_ff @(posedge clk_i) begin
    bad_determinant_o <= bad_q[L_BAD];
  end

  assign done_o = vld_q[L_VLD];
  assign s_11_o = s[0];
  assign s_12_o = s[1];
  assign s_13_o = s[2];
  assign s_21_o = s[3];
  assign s_22_o = s[4];
  assign s_23_o = s[5];
  assign s_31_o = s[6];
  assign s_32_o = s[7];
  assign s_33_o = s[8];

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mrds_pkg::*;

  typedef enum logic [1:0] {OP_TENSOR, OP_CFG, OP_DRAIN} op_e;

  typedef struct {
    op_e                     op;
    word_t                   c[9];
    logic [CFG_IDX_BITS-1:0] idx;
    word_t                   data;
    int                      idle_pct;
  } action_t;

  typedef struct {
    word_t s[9];
    logic  bad;
  } stress_t;

  localparam int DRAIN_CYCLES = T_OUT + 20;
  localparam int REPORT_LIMIT = 10;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  word_t                   c_in[9];
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [WORD_BITS-1:0]    cfg_data_i;
  logic                    done_o;
  word_t                   s_out[9];
  logic                    bad_determinant_o;

  action_t action_q[$];
  stress_t stress_q[$];
  fx_t     m10_model, m01_model;
  int      mismatches;
  int      failures;
  logic    took;
  logic    stim_done;
  int      drain_cnt;
  action_t cur;

  mooney_rivlin_deviatoric_stress dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .c_11_i(c_in[0]), .c_12_i(c_in[1]), .c_13_i(c_in[2]),
    .c_21_i(c_in[3]), .c_22_i(c_in[4]), .c_23_i(c_in[5]),
    .c_31_i(c_in[6]), .c_32_i(c_in[7]), .c_33_i(c_in[8]),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done_o,
    .s_11_o(s_out[0]), .s_12_o(s_out[1]), .s_13_o(s_out[2]),
    .s_21_o(s_out[3]), .s_22_o(s_out[4]), .s_23_o(s_out[5]),
    .s_31_o(s_out[6]), .s_32_o(s_out[7]), .s_33_o(s_out[8]),
    .bad_determinant_o
  );

  // ---------------- fixed-point arithmetic of the stress kernel
  function automatic fx_t clip_mag(ufx_t m, logic neg);
    if (!neg) begin
      return m[FX_BITS-1] ? FX_MAX : fx_t'(m);
    end
    return m[FX_BITS-1] ? FX_MIN : -fx_t'(m);
  endfunction

  function automatic ufx_t abs_u(fx_t v);
    return v < 0 ? ufx_t'(-v) : ufx_t'(v);
  endfunction

  function automatic fx_t add_q(fx_t a, fx_t b);
    logic signed [FX_BITS:0] s;
    s = {a[FX_BITS-1], a} + {b[FX_BITS-1], b};
    if (s > $signed({1'b0, FX_MAX})) return FX_MAX;
    if (s < $signed({1'b1, FX_MIN})) return FX_MIN;
    return fx_t'(s);
  endfunction

  function automatic fx_t sub_q(fx_t a, fx_t b);
    logic signed [FX_BITS:0] s;
    s = {a[FX_BITS-1], a} - {b[FX_BITS-1], b};
    if (s > $signed({1'b0, FX_MAX})) return FX_MAX;
    if (s < $signed({1'b1, FX_MIN})) return FX_MIN;
    return fx_t'(s);
  endfunction

  // Round half away from zero on magnitudes, then saturate
  function automatic fx_t mul_q(fx_t a, fx_t b);
    logic         neg;
    logic [127:0] p;
    neg = (a < 0) != (b < 0);
    p = {64'd0, abs_u(a)} * {64'd0, abs_u(b)};
    p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (p[127:64] != 0) return neg ? FX_MIN : FX_MAX;
    return clip_mag(p[63:0], neg);
  endfunction

  // n / d with d > 0, rounded to nearest, ties away from zero
  function automatic fx_t div_q(fx_t n, fx_t d);
    logic         neg;
    logic [127:0] num, dv, q, r;
    neg = n < 0;
    num = {64'd0, abs_u(n)} << FRAC_BITS;
    dv  = {64'd0, ufx_t'(d)};
    if ((num >> 64) >= dv) return neg ? FX_MIN : FX_MAX;
    q = num / dv;
    r = num % dv;
    if (r >= dv - r) begin
      if (q[63:0] == '1) return neg ? FX_MIN : FX_MAX;
      q = q + 1;
    end
    return clip_mag(q[63:0], neg);
  endfunction

  function automatic fx_t third_q(fx_t v);
    return clip_mag((abs_u(v) + 1) / 3, v < 0);
  endfunction

  // Newton iteration for det^-1/3 from a power-of-two start
  function automatic fx_t inv_cube_root(fx_t d);
    int  lead, ex, sh;
    fx_t y, t;
    lead = 0;
    for (int i = 0; i < 64; i++) if (d[i]) lead = i;
    ex = (lead - FRAC_BITS + 128) / 3 - 42;
    sh = FRAC_BITS - ex;
    if (sh < 0) sh = 0;
    y = fx_t'(1) <<< sh;
    for (int k = 0; k < NEWTON_STEPS; k++) begin
      t = mul_q(mul_q(mul_q(mul_q(d, y), y), y), y);
      y = third_q(sub_q(add_q(add_q(y, y), add_q(y, y)), t));
    end
    return y;
  endfunction

  function automatic stress_t stress_of(word_t w[9], fx_t m10, fx_t m01);
    stress_t r;
    fx_t c[9], adj[9];
    fx_t det, tr, cc, y, k1, k2, ttr, tb, inv, t1, t2, s;
    for (int i = 0; i < 9; i++) c[i] = fx_t'(w[i]);
    adj[0] = sub_q(mul_q(c[4], c[8]), mul_q(c[5], c[7]));
    adj[1] = sub_q(mul_q(c[2], c[7]), mul_q(c[1], c[8]));
    adj[2] = sub_q(mul_q(c[1], c[5]), mul_q(c[2], c[4]));
    adj[3] = sub_q(mul_q(c[5], c[6]), mul_q(c[3], c[8]));
    adj[4] = sub_q(mul_q(c[0], c[8]), mul_q(c[2], c[6]));
    adj[5] = sub_q(mul_q(c[2], c[3]), mul_q(c[0], c[5]));
    adj[6] = sub_q(mul_q(c[3], c[7]), mul_q(c[4], c[6]));
    adj[7] = sub_q(mul_q(c[1], c[6]), mul_q(c[0], c[7]));
    adj[8] = sub_q(mul_q(c[0], c[4]), mul_q(c[1], c[3]));
    det = add_q(add_q(mul_q(c[0], adj[0]), mul_q(c[1], adj[3])), mul_q(c[2], adj[6]));
    r.bad = det <= 0;
    for (int i = 0; i < 9; i++) r.s[i] = '0;
    if (r.bad) return r;
    tr = add_q(add_q(c[0], c[4]), c[8]);
    cc = '0;
    for (int i = 0; i < 9; i++) cc = add_q(cc, mul_q(c[i], c[i]));
    y  = inv_cube_root(det);
    k1 = mul_q(m10, y);
    k1 = add_q(k1, k1);
    k2 = mul_q(m01, mul_q(y, y));
    k2 = add_q(k2, k2);
    ttr = third_q(tr);
    tb  = third_q(sub_q(cc, mul_q(tr, tr)));
    for (int i = 0; i < 9; i++) begin
      logic diag;
      diag = (i == 0 || i == 4 || i == 8);
      inv = div_q(adj[i], det);
      t1 = sub_q(diag ? ONE_Q : fx_t'(0), mul_q(ttr, inv));
      t2 = add_q(sub_q(diag ? tr : fx_t'(0), c[i]), mul_q(tb, inv));
      s  = add_q(mul_q(k1, t1), mul_q(k2, t2));
      if (s > WORD_MAX_FX) s = WORD_MAX_FX;
      if (s < WORD_MIN_FX) s = WORD_MIN_FX;
      r.s[i] = word_t'(s);
    end
    return r;
  endfunction

  // ---------------- stimulus helpers
  function automatic action_t tensor_act(word_t c[9], int pct);
    action_t a;
    a.op = OP_TENSOR;
    a.c = c;
    a.idx = '0;
    a.data = '0;
    a.idle_pct = pct;
    return a;
  endfunction

  task automatic push_cfg(logic [CFG_IDX_BITS-1:0] idx, word_t data);
    action_t a;
    a.op = OP_CFG;
    a.idx = idx;
    a.data = data;
    a.idle_pct = 0;
    action_q.push_back(a);
  endtask

  task automatic push_drain();
    action_t a;
    a.op = OP_DRAIN;
    a.idle_pct = 0;
    action_q.push_back(a);
  endtask

  // Near-identity deformation, occasionally scaled, occasionally unsymmetric
  function automatic action_t physical_tensor(int pct);
    word_t c[9];
    int    sh;
    sh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 0;
    for (int i = 0; i < 9; i++) begin
      if (i == 0 || i == 4 || i == 8) begin
        c[i] = word_t'(ONE_Q) + $signed($urandom_range(0, 32'h0300_0000)) - 32'sh0080_0000;
      end else begin
        c[i] = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      end
    end
    if ($urandom_range(0, 3) != 0) begin
      c[3] = c[1];
      c[6] = c[2];
      c[7] = c[5];
    end
    for (int i = 0; i < 9; i++) c[i] = c[i] <<< sh;
    return tensor_act(c, pct);
  endfunction

  function automatic action_t noise_tensor(int pct);
    word_t c[9];
    int    sh;
    sh = $urandom_range(0, 31);
    for (int i = 0; i < 9; i++) c[i] = $signed($urandom()) >>> sh;
    if ($urandom_range(0, 3) == 0) for (int i = 0; i < 9; i++) c[i] = $urandom();
    return tensor_act(c, pct);
  endfunction

  task automatic push_directed();
    word_t z[9], t[9];
    word_t vals[6];
    vals = '{32'sh0100_0000, 32'sh7fff_ffff, -32'sh8000_0000, 32'sh0000_0001,
             32'sh0010_0000, -32'sh0100_0000};
    for (int i = 0; i < 9; i++) z[i] = '0;
    action_q.push_back(tensor_act(z, 0));
    // diagonal tensors: identity, extremes, tiny determinant, negative determinant
    foreach (vals[v]) begin
      t = z;
      t[0] = vals[v]; t[4] = vals[v]; t[8] = vals[v];
      action_q.push_back(tensor_act(t, 0));
    end
    t = z;
    t[0] = 32'sh0100_0000; t[4] = 32'sh0100_0000; t[8] = -32'sh0100_0000;
    action_q.push_back(tensor_act(t, 0));
    // all entries at one extreme
    for (int i = 0; i < 9; i++) t[i] = 32'sh7fff_ffff;
    action_q.push_back(tensor_act(t, 0));
    for (int i = 0; i < 9; i++) t[i] = -32'sh8000_0000;
    action_q.push_back(tensor_act(t, 0));
    // unsymmetric shear and a large stretch
    t = z;
    t[0] = 32'sh0200_0000; t[1] = 32'sh0080_0000; t[4] = 32'sh0100_0000;
    t[8] = 32'sh0300_0000; t[5] = -32'sh0040_0000;
    action_q.push_back(tensor_act(t, 0));
    t = z;
    t[0] = 32'sh7000_0000; t[4] = 32'sh0001_0000; t[8] = 32'sh0100_0000;
    action_q.push_back(tensor_act(t, 0));
    for (int i = 0; i < 6; i++) action_q.push_back(physical_tensor(0));
    push_drain();
  endtask

  // ---------------- clock and reset
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // ---------------- fill the action list: config phases, each with traffic
  initial begin
    word_t m10s[8], m01s[8];
    int    pcts[3];
    m10s = '{32'sh0100_0000, 32'sh7fff_ffff, -32'sh8000_0000, 32'sh0000_0000,
             32'sh0080_0000, -32'sh0040_0000, 32'sh7fff_ffff, 32'sh0000_0001};
    m01s = '{32'sh0080_0000, 32'sh7fff_ffff, -32'sh8000_0000, 32'sh0100_0000,
             32'sh0000_0000, 32'sh0020_0000, -32'sh8000_0000, -32'sh0000_0001};
    pcts = '{32, 0, 0};
    // traffic at reset values first
    push_directed();
    for (int p = 0; p < 8; p++) begin
      push_cfg(CFG_M10, m10s[p]);
      push_cfg(CFG_M01, m01s[p]);
      // out-of-range indexes must be ignored
      if (p % 3 == 0) push_cfg(CFG_IDX_BITS'(2), $urandom());
      if (p % 3 == 1) push_cfg(CFG_IDX_BITS'(3), $urandom());
      if (p < 2) push_directed();
      for (int i = 0; i < 200; i++) begin
        int pct;
        pct = (p < 3) ? 32 : (p < 5) ? 49 : 0;
        if ($urandom_range(0, 99) < 80) action_q.push_back(physical_tensor(pct));
        else action_q.push_back(noise_tensor(pct));
      end
      push_drain();
    end
  end

  // ---------------- acceptance flag for the driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      took <= 1'b0;
    end else begin
      took <= start_i && !busy_o;
    end
  end

  // ---------------- driver: change inputs on the falling edge
  initial begin
    start_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    for (int i = 0; i < 9; i++) c_in[i] = '0;
    m10_model = '0;
    m01_model = '0;
    stim_done = 1'b0;
    drain_cnt = 0;
    cur.op = OP_DRAIN;
  end

  always @(negedge clk_i) begin
    if (rst_ni && !stim_done) begin
      // hold an item that has not been taken yet
      if (start_i && !took) begin
      end else if (drain_cnt > 0) begin
        start_i <= 1'b0;
        cfg_we_i <= 1'b0;
        if (stress_q.size() == 0) drain_cnt <= drain_cnt - 1;
      end else if (action_q.size() == 0) begin
        start_i <= 1'b0;
        cfg_we_i <= 1'b0;
        stim_done <= 1'b1;
      end else if (action_q[0].op == OP_TENSOR &&
                   $urandom_range(0, 99) < action_q[0].idle_pct) begin
        start_i <= 1'b0;
        cfg_we_i <= 1'b0;
      end else begin
        cur = action_q.pop_front();
        start_i <= (cur.op == OP_TENSOR);
        cfg_we_i <= (cur.op == OP_CFG);
        case (cur.op)
          OP_TENSOR: begin
            for (int i = 0; i < 9; i++) c_in[i] <= cur.c[i];
          end
          OP_CFG: begin
            cfg_idx_i <= cur.idx;
            cfg_data_i <= cur.data;
            if (cur.idx == CFG_M10) m10_model = fx_t'(cur.data);
            if (cur.idx == CFG_M01) m01_model = fx_t'(cur.data);
          end
          default: drain_cnt <= DRAIN_CYCLES;
        endcase
      end
    end
  end

  // ---------------- monitor: predict on accept, check on done
  always @(posedge clk_i) begin
    stress_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) stress_q.push_back(stress_of(c_in, m10_model, m01_model));
      if (done_o) begin
        if (stress_q.size() == 0) begin
          failures++;
          if (mismatches < REPORT_LIMIT) $display("unexpected transaction at %0t", $realtime);
          mismatches++;
        end else begin
          logic bad_hit;
          want = stress_q.pop_front();
          bad_hit = (want.bad !== bad_determinant_o);
          for (int i = 0; i < 9; i++) if (want.s[i] !== s_out[i]) bad_hit = 1'b1;
          if (bad_hit) begin
            failures++;
            if (mismatches < REPORT_LIMIT) begin
              $display("mismatch at %0t: bad_determinant exp %0b got %0b",
                       $realtime, want.bad, bad_determinant_o);
              for (int i = 0; i < 9; i++)
                if (want.s[i] !== s_out[i])
                  $display("  s[%0d] exp %h got %h", i, want.s[i], s_out[i]);
            end
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------- end of run
  initial begin
    mismatches = 0;
    failures = 0;
    wait (stim_done);
    wait (stress_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
